/* sv/tmvs_pkg.sv */
// Shared widths, codes and reset values for the trimmed mean / variance block.
`default_nettype none
package tmvs_pkg;
  localparam int SAMPLE_W = 16;
  localparam int AVG_W    = 24;
  localparam int VAR_W    = 40;
  localparam int SD_W     = 24;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_AVG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VAR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SD    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_SD;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVF   = 2'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;
endpackage
`default_nettype wire

/* sv/tmvs_sample_if.sv */
// Sample input channel.
`default_nettype none
interface tmvs_sample_if;
  import tmvs_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

/* sv/tmvs_result_if.sv */
// Result output channel.
`default_nettype none
interface tmvs_result_if;
  import tmvs_pkg::*;
  logic                valid;
  logic                ready;
  logic [AVG_W-1:0]    average;
  logic [VAR_W-1:0]    variance;
  logic [SD_W-1:0]     std_dev;
  status_t             status;
  modport source (output valid, output average, output variance, output std_dev,
                  output status, input ready);
  modport sink   (input valid, input average, input variance, input std_dev,
                  input status, output ready);
endinterface
`default_nettype wire

/* sv/tmvs_cfg_if.sv */
// Mode register write channel.
`default_nettype none
interface tmvs_cfg_if;
  import tmvs_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface
`default_nettype wire

/* sv/tmvs_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module tmvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* sv/trimmed_mean_variance_stddev.sv */
// Trimmed mean, variance and standard deviation over a set of samples.
// Samples load one per cycle while ready is high; after the last beat the set is
//   scanned from the store, then a restoring divide for the mean, three shift-add
//   multiplies, a second restoring divide and the root run as the mode needs, then the result is presented.
// Throughput: one set at a time; ready is low from the last beat until the result
//   is taken into the output register.
// Reset: synchronous, clears the set, the output valid and sets mode to 2.
`default_nettype none
module trimmed_mean_variance_stddev #(
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tmvs_cfg_if.sink      cfg,
  tmvs_sample_if.sink   samples,
  tmvs_result_if.source results
);
  import tmvs_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = SAMPLE_W + AW;
  localparam int QW  = 2 * SAMPLE_W + AW;
  localparam int NW  = CW + QW;
  localparam int DW  = NW + 8;
  localparam int DVW = 2 * CW;
  localparam int SQW = VAR_W + 8;
  localparam int RW  = SD_W + 2;
  localparam int ITW = $clog2(DW + 1);

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_SCAN      = 4'd1;
  localparam logic [3:0] ST_DIVA      = 4'd2;
  localparam logic [3:0] ST_MQ        = 4'd3;
  localparam logic [3:0] ST_MSS       = 4'd4;
  localparam logic [3:0] ST_MMM       = 4'd5;
  localparam logic [3:0] ST_DIVV      = 4'd6;
  localparam logic [3:0] ST_SQRT      = 4'd7;
  localparam logic [3:0] ST_RES       = 4'd8;
  localparam logic [3:0] ST_SQRT_DONE = 4'd9;

  logic [3:0]    state;
  mode_t         mode;
  logic [CW-1:0] count;
  logic          ovf;
  sample_t       max_value, min_value;
  logic [CW-1:0] max_position, min_position;

  // scan pipeline
  logic [CW-1:0]         idx;
  logic                  p1_valid, p1_keep, p2_valid, p2_keep;
  sample_t               d2;
  logic [2*SAMPLE_W-1:0] sq2;
  logic [SW-1:0]         s_acc;
  logic [QW-1:0]         q_acc;

  // shared multiply / divide / root datapath
  logic [ITW-1:0] it;
  logic [NW-1:0]  mc, acc, mq, num;
  logic [SW-1:0]  mp;
  logic [DVW-1:0] dvs;
  logic [DW-1:0]  dq;
  logic [DVW:0]   drem;
  logic [SQW-1:0] sv;
  logic [RW-1:0]  srem;
  logic [SD_W-1:0] root;

  logic [AVG_W-1:0] avg_r;
  logic [VAR_W-1:0] var_r;
  logic [SD_W-1:0]  sd_r;
  status_t          st_r;

  logic               out_valid;
  logic [AVG_W-1:0]   out_avg;
  logic [VAR_W-1:0]   out_var;
  logic [SD_W-1:0]    out_sd;
  status_t            out_st;

  logic          accept, store_ok, ram_we;
  logic [CW-1:0] count_next, m, drop_hi;
  logic [AW-1:0] ram_addr;
  sample_t       ram_rdata;
  logic [DVW:0]  rem_sh;
  logic          div_ge;
  logic [RW-1:0] sq_sh, sq_trial;
  logic          sq_ge;

  assign accept     = samples.valid && samples.ready;
  assign store_ok   = count < CW'(MAX_SAMPLES);
  assign count_next = store_ok ? count + 1'b1 : count;
  assign ram_we     = accept && store_ok;
  assign ram_addr   = (state == ST_LOAD) ? count[AW-1:0] : idx[AW-1:0];
  assign m          = count - CW'(2);
  assign drop_hi    = (max_position == min_position) ? max_position + 1'b1 : max_position;

  assign rem_sh   = {drem[DVW-1:0], dq[DW-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs};
  assign sq_sh    = {srem[RW-3:0], sv[SQW-1:SQW-2]};
  assign sq_trial = {root, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  assign samples.ready   = (state == ST_LOAD);
  // hold mode writes off while a set is being computed
  assign cfg.ready       = (state == ST_LOAD);
  assign results.valid    = out_valid;
  assign results.average  = out_avg;
  assign results.variance = out_var;
  assign results.std_dev  = out_sd;
  assign results.status   = out_st;

  tmvs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (samples.sample),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      mode <= cfg.mode;
    end
  end

  // scan pipeline payload
  always_ff @(posedge clk) begin
    d2  <= ram_rdata;
    sq2 <= (2*SAMPLE_W)'(ram_rdata) * (2*SAMPLE_W)'(ram_rdata);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      max_position <= '0;
      min_position <= '0;
    end else begin
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              if (count == '0) begin
                max_value    <= samples.sample;
                min_value    <= samples.sample;
                max_position <= '0;
                min_position <= '0;
              end else begin
                if (samples.sample > max_value) begin
                  max_value    <= samples.sample;
                  max_position <= count;
                end
                if (samples.sample < min_value) begin
                  min_value    <= samples.sample;
                  min_position <= count;
                end
              end
            end else begin
              ovf <= 1'b1;
            end
            count <= count_next;
            if (samples.last) begin
              if (count_next < CW'(3)) begin
                avg_r <= '0;
                var_r <= '0;
                sd_r  <= '0;
                st_r  <= STATUS_SHORT;
                state <= ST_RES;
              end else begin
                idx   <= '0;
                s_acc <= '0;
                q_acc <= '0;
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          // issue one read a cycle, square, then accumulate kept samples
          p1_valid <= idx < count;
          p1_keep  <= idx != drop_hi && idx != min_position;
          if (idx < count) begin
            idx <= idx + 1'b1;
          end
          p2_valid <= p1_valid;
          p2_keep  <= p1_keep;
          if (p2_valid && p2_keep) begin
            s_acc <= s_acc + SW'(d2);
            q_acc <= q_acc + QW'(sq2);
          end
          if (idx == count && !p1_valid && !p2_valid) begin
            avg_r <= '0;
            var_r <= '0;
            sd_r  <= '0;
            st_r  <= ovf ? STATUS_OVF : STATUS_OK;
            if (mode == MODE_AVG || mode == MODE_VAR || mode == MODE_SD) begin
              dq    <= DW'({s_acc, 8'h00});
              dvs   <= DVW'(m);
              drem  <= '0;
              it    <= '0;
              state <= ST_DIVA;
            end else begin
              state <= ST_RES;
            end
          end
        end
        ST_DIVA, ST_DIVV: begin
          drem <= div_ge ? rem_sh - {1'b0, dvs} : rem_sh;
          dq   <= {dq[DW-2:0], div_ge};
          it   <= it + 1'b1;
          if (it == ITW'(DW)) begin
            it <= '0;
            if (state == ST_DIVA) begin
              avg_r <= dq[AVG_W-1:0];
              if (mode == MODE_AVG) begin
                state <= ST_RES;
              end else begin
                mc    <= NW'(q_acc);
                mp    <= SW'(m);
                acc   <= '0;
                state <= ST_MQ;
              end
            end else begin
              var_r <= dq[VAR_W-1:0];
              if (mode == MODE_SD) begin
                sv    <= {dq[VAR_W-1:0], 8'h00};
                srem  <= '0;
                root  <= '0;
                state <= ST_SQRT;
              end else begin
                state <= ST_RES;
              end
            end
          end
        end
        ST_MQ, ST_MSS, ST_MMM: begin
          // shift-add multiply, one multiplier bit a cycle
          if (mp[0]) begin
            acc <= acc + mc;
          end
          mc <= mc << 1;
          mp <= mp >> 1;
          it <= it + 1'b1;
          if (it == ITW'(SW)) begin
            it  <= '0;
            acc <= '0;
            unique case (state)
              ST_MQ: begin
                mq    <= acc;
                mc    <= NW'(s_acc);
                mp    <= s_acc;
                state <= ST_MSS;
              end
              ST_MSS: begin
                num   <= mq - acc;
                mc    <= NW'(m);
                mp    <= SW'(m);
                state <= ST_MMM;
              end
              default: begin
                dq    <= {num, 8'h00};
                dvs   <= acc[DVW-1:0];
                drem  <= '0;
                state <= ST_DIVV;
              end
            endcase
          end
        end
        ST_SQRT: begin
          // digit-by-digit root, two radicand bits a cycle
          srem <= sq_ge ? sq_sh - sq_trial : sq_sh;
          root <= {root[SD_W-2:0], sq_ge};
          sv   <= sv << 2;
          it   <= it + 1'b1;
          if (it == ITW'(SD_W - 1)) begin
            it    <= '0;
            state <= ST_SQRT_DONE;
          end
        end
        ST_RES: begin
          if (!out_valid || results.ready) begin
            out_valid    <= 1'b1;
            out_avg      <= avg_r;
            out_var      <= var_r;
            out_sd       <= sd_r;
            out_st       <= st_r;
            count        <= '0;
            ovf          <= 1'b0;
            max_position <= '0;
            min_position <= '0;
            state        <= ST_LOAD;
          end
        end
        ST_SQRT_DONE: begin
          sd_r  <= root;
          state <= ST_RES;
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_ready_only_load: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> state == ST_LOAD)
    else $error("ready outside load");
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_st == STATUS_SHORT) |-> (out_avg == '0 && out_var == '0 && out_sd == '0))
    else $error("short set with nonzero result");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("count over capacity");
  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx <= count)
    else $error("scan index past count");
  a_res_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_st == STATUS_OK || out_st == STATUS_SHORT || out_st == STATUS_OVF))
    else $error("bad status");
endmodule
`default_nettype wire
